// ===== hdl/cbhd_pkg.sv =====
package cbhd_pkg;

  localparam int BTN_W   = 3;
  localparam int BTN_CNT = 1 << BTN_W;
  localparam int TMR_W   = 16;
  localparam int REG_W   = 16;
  localparam int MASK_W  = 8;
  localparam int EV_MAX  = 6;
  localparam int EV_CW   = 3;

  typedef enum logic [2:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_CLICK  = 3'd2,
    EV_DOUBLE = 3'd3,
    EV_HOLD   = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_WINDOW   = 3'd1,
    CFG_HOLD     = 3'd2,
    CFG_REPEAT   = 3'd3,
    CFG_ACT_HIGH = 3'd4,
    CFG_RPT_MASK = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0]  debounce;
    logic [REG_W-1:0]  window;
    logic [REG_W-1:0]  hold;
    logic [REG_W-1:0]  rpt;
    logic [MASK_W-1:0] act_high;
    logic [MASK_W-1:0] rpt_mask;
  } cfg_t;

  typedef struct packed {
    logic             prev;
    logic             set_run;
    logic [TMR_W-1:0] set_left;
    logic             win_run;
    logic [TMR_W-1:0] win_left;
    logic             hold_run;
    logic [TMR_W-1:0] hold_left;
    logic             rpt_run;
    logic [TMR_W-1:0] rpt_left;
  } btn_st_t;

  localparam int ST_W = $bits(btn_st_t);
  localparam btn_st_t ST_RST = btn_st_t'({1'b1, {(ST_W-1){1'b0}}});

  typedef struct packed {
    ev_kind_t [EV_MAX-1:0] kind;
    logic [EV_CW-1:0]      cnt;
  } ev_list_t;

  function automatic logic [TMR_W-1:0] load_val(input logic [REG_W-1:0] v);
    logic [32:0] x;
    logic [32:0] top;
    x   = 33'(v);
    top = (33'd1 << TMR_W) - 33'd1;
    if (x == 33'd0) x = 33'd1;
    if (x > top) x = top;
    return x[TMR_W-1:0];
  endfunction

  function automatic logic [TMR_W-1:0] tick(input logic [TMR_W-1:0] left);
    return left - TMR_W'(left != '0);
  endfunction

endpackage

// ===== hdl/cbhd_if.sv =====
interface cbhd_in_if;
  import cbhd_pkg::*;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_index;
  logic             raw_level;

  modport source (output valid, output button_index, output raw_level, input ready);
  modport sink   (input valid, input button_index, input raw_level, output ready);
endinterface

interface cbhd_out_if;
  import cbhd_pkg::*;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] event_button;
  logic [2:0]       event_kind;
  logic             last_of_run;

  modport source (output valid, output event_button, output event_kind,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_button, input event_kind,
                  input last_of_run, output ready);
endinterface

// ===== hdl/cbhd_step.sv =====
module cbhd_step
  import cbhd_pkg::*;
(
  input  btn_st_t          st_i,
  input  logic [BTN_W-1:0] btn,
  input  logic             level,
  input  cfg_t             cfg,
  output btn_st_t          st_o,
  output ev_list_t         ev_o
);

  always_comb begin
    btn_st_t  s;
    ev_list_t ev;
    logic     fw;
    logic     fh;
    logic     fr;
    logic     pressed;
    s  = st_i;
    ev = '0;
    fw = 1'b0;
    fh = 1'b0;
    fr = 1'b0;
    pressed = ~(level ^ cfg.act_high[btn]);

    // debounce
    if (s.set_run) begin
      s.set_left = tick(s.set_left);
      if (s.set_left == '0) begin
        s.set_run = 1'b0;
        if (pressed) begin
          ev.kind[ev.cnt] = EV_DOWN;
          ev.cnt = ev.cnt + EV_CW'(1);
          ev.kind[ev.cnt] = EV_CLICK;
          ev.cnt = ev.cnt + EV_CW'(1);
          if (!s.hold_run) begin
            s.hold_run  = 1'b1;
            s.hold_left = load_val(cfg.hold);
            fh = 1'b1;
          end
          if (!s.win_run) begin
            s.win_run  = 1'b1;
            s.win_left = load_val(cfg.window);
            fw = 1'b1;
          end else begin
            ev.kind[ev.cnt] = EV_DOUBLE;
            ev.cnt = ev.cnt + EV_CW'(1);
            s.win_run  = 1'b0;
            s.win_left = '0;
          end
        end else begin
          ev.kind[ev.cnt] = EV_UP;
          ev.cnt = ev.cnt + EV_CW'(1);
          s.hold_run  = 1'b0;
          s.hold_left = '0;
          s.rpt_run   = 1'b0;
          s.rpt_left  = '0;
        end
      end
    end

    // edge
    if (level != s.prev) begin
      if (!s.set_run) begin
        s.set_run  = 1'b1;
        s.set_left = load_val(cfg.debounce);
      end
      s.prev = level;
    end

    // double-click window
    if (s.win_run && !fw) begin
      s.win_left = tick(s.win_left);
      if (s.win_left == '0) s.win_run = 1'b0;
    end

    // hold
    if (s.hold_run && !fh) begin
      s.hold_left = tick(s.hold_left);
      if (s.hold_left == '0) begin
        s.hold_run = 1'b0;
        ev.kind[ev.cnt] = EV_HOLD;
        ev.cnt = ev.cnt + EV_CW'(1);
        if (cfg.rpt_mask[btn]) begin
          ev.kind[ev.cnt] = EV_CLICK;
          ev.cnt = ev.cnt + EV_CW'(1);
          if (!s.rpt_run) begin
            s.rpt_run  = 1'b1;
            s.rpt_left = load_val(cfg.rpt);
            fr = 1'b1;
          end
        end
      end
    end

    // repeat
    if (s.rpt_run && !fr) begin
      s.rpt_left = tick(s.rpt_left);
      if (s.rpt_left == '0) begin
        ev.kind[ev.cnt] = EV_CLICK;
        ev.cnt = ev.cnt + EV_CW'(1);
        s.rpt_left = load_val(cfg.rpt);
      end
    end

    st_o = s;
    ev_o = ev;
  end

endmodule

// ===== hdl/button_click_hold_detector.sv =====
// channel  | dir | handshake    | payload
// in_ch    | in  | valid/ready  | button_index[2:0], raw_level
// out_ch   | out | valid/ready  | event_button[2:0], event_kind[2:0], last_of_run
// cfg      | in  | cfg_we       | cfg_idx[2:0], cfg_wdata[15:0]
//
// An item reads its button's state from the state memory at acceptance, is
// evaluated in the next cycle and written back when it moves on, with forwarding
// when the next item names the same button. An item with n events (up to 6) holds
// the output register until all are taken; one with none does not load it. The
// first event is offered once the item is loaded there. Reset sets per-entry
// valid bits to zero: an entry not yet written reads as its reset state, so no
// clearing pass is needed. A stalled output holds one item in the evaluate stage.
module button_click_hold_detector
  import cbhd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  cbhd_in_if.sink          in_ch,
  cbhd_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata
);

  cfg_t                   cfg_r;
  btn_st_t                mem [BTN_CNT];
  btn_st_t                mem_q_r;
  btn_st_t                fwd_data_r;
  logic                   fwd_r;
  logic                   vld_q_r;
  logic [BTN_CNT-1:0]     vld_r;
  logic                   b_valid_r;
  logic [BTN_W-1:0]       b_btn_r;
  logic                   b_lvl_r;
  btn_st_t                st_cur;
  btn_st_t                st_nxt;
  ev_list_t               ev;
  ev_kind_t [EV_MAX-1:0]  em_kind_r;
  logic [EV_CW-1:0]       em_cnt_r;
  logic [BTN_W-1:0]       em_btn_r;
  logic                   acc;
  logic                   out_fire;
  logic                   can_load;
  logic                   b_move;
  logic                   em_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= REG_W'(20);
      cfg_r.window   <= REG_W'(300);
      cfg_r.hold     <= REG_W'(1000);
      cfg_r.rpt      <= REG_W'(100);
      cfg_r.act_high <= '0;
      cfg_r.rpt_mask <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata;
        CFG_WINDOW:   cfg_r.window   <= cfg_wdata;
        CFG_HOLD:     cfg_r.hold     <= cfg_wdata;
        CFG_REPEAT:   cfg_r.rpt      <= cfg_wdata;
        CFG_ACT_HIGH: cfg_r.act_high <= cfg_wdata[MASK_W-1:0];
        CFG_RPT_MASK: cfg_r.rpt_mask <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_fire = out_ch.valid && out_ch.ready;
  assign can_load = (em_cnt_r == '0) || ((em_cnt_r == EV_CW'(1)) && out_ch.ready);
  assign b_move   = b_valid_r && ((ev.cnt == '0) || can_load);
  assign em_load  = b_move && (ev.cnt != '0);
  assign in_ch.ready = !b_valid_r || b_move;
  assign acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (b_move) mem[b_btn_r] <= st_nxt;
    if (acc) mem_q_r <= mem[in_ch.button_index];
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_btn_r    <= in_ch.button_index;
      b_lvl_r    <= in_ch.raw_level;
      fwd_data_r <= st_nxt;
    end
    if (em_load) begin
      em_btn_r  <= b_btn_r;
      em_kind_r <= ev.kind;
    end else if (out_fire) begin
      for (int i = 0; i < EV_MAX - 1; i++) em_kind_r[i] <= em_kind_r[i+1];
      em_kind_r[EV_MAX-1] <= EV_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      vld_r     <= '0;
      fwd_r     <= 1'b0;
      vld_q_r   <= 1'b0;
      em_cnt_r  <= '0;
    end else begin
      if (acc) begin
        b_valid_r <= 1'b1;
        fwd_r     <= b_move && (b_btn_r == in_ch.button_index);
        vld_q_r   <= vld_r[in_ch.button_index];
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) vld_r[b_btn_r] <= 1'b1;
      if (em_load) em_cnt_r <= ev.cnt;
      else if (out_fire) em_cnt_r <= em_cnt_r - EV_CW'(1);
    end
  end

  assign st_cur = fwd_r ? fwd_data_r : (vld_q_r ? mem_q_r : ST_RST);

  cbhd_step u_step (
    .st_i  (st_cur),
    .btn   (b_btn_r),
    .level (b_lvl_r),
    .cfg   (cfg_r),
    .st_o  (st_nxt),
    .ev_o  (ev)
  );

  assign out_ch.valid        = em_cnt_r != '0;
  assign out_ch.event_button = em_btn_r;
  assign out_ch.event_kind   = em_kind_r[0];
  assign out_ch.last_of_run  = em_cnt_r == EV_CW'(1);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    em_cnt_r <= EV_CW'(EV_MAX))
    else $error("event count above limit");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_of_run && !em_load |=> !out_ch.valid)
    else $error("events remain after last of run");

  a_no_event_moves: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && ev.cnt == '0 |-> b_move)
    else $error("item without events stalled");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    em_load |-> em_cnt_r == '0 || (em_cnt_r == EV_CW'(1) && out_fire))
    else $error("emitter overwritten");
`endif

endmodule
